// File: hdl/grid_edge_traversal_cost_defines.svh
// Assertion macros for the grid edge traversal cost block.
`ifndef GRID_EDGE_TRAVERSAL_COST_DEFINES_SVH
`define GRID_EDGE_TRAVERSAL_COST_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GETC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid edge cost check failed");
// next-cycle implication
`define GETC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid edge cost check failed");
`else
`define GETC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GETC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: hdl/getc_pkg.sv
// Shared types, codes and tables of the grid edge traversal cost block.
package getc_pkg;

   // unsigned grid dimension / index width (covers grids up to 4096 cells a side)
   localparam int DIM_W = 13;
   // signed coordinate width for window bounds
   localparam int SC_W  = 14;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_UPDATE = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_COST   = 1'b1;

   // register indexes
   localparam logic [2:0] CSR_ROWS_IN_USE     = 3'd0;
   localparam logic [2:0] CSR_COLS_IN_USE     = 3'd1;
   localparam logic [2:0] CSR_WINDOW_RADIUS   = 3'd2;
   localparam logic [2:0] CSR_BLOCK_THRESHOLD = 3'd3;
   localparam logic [2:0] CSR_EDGE_COST       = 3'd4;
   localparam logic [2:0] CSR_DIAGONAL_COST   = 3'd5;

   typedef struct packed {
      logic [1:0] op;
      logic [8:0] row;
      logic [8:0] col;
      logic [7:0] cell_value;
      logic [2:0] direction;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [8:0]  out_row;
      logic [8:0]  out_col;
      logic        blocked;
      logic [15:0] cost;
      logic [7:0]  window_max;
   } rsp_type;

   typedef struct packed {
      logic [8:0]  rows_in_use;
      logic [8:0]  cols_in_use;
      logic [3:0]  window_radius;
      logic [7:0]  block_threshold;
      logic [15:0] edge_cost;
      logic [15:0] diagonal_cost;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CMP,
      ST_CELL,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // cell offsets relative to the node: {row minus one, col minus one}
   typedef struct packed {
      logic       two;
      logic [1:0] a;
      logic [1:0] b;
   } cell_pair_type;

   // cells examined for each neighbor direction
   function automatic cell_pair_type dir_cells(input logic [2:0] dir);
      cell_pair_type p;
      p = '0;
      case (dir)
         3'd0: p = '{two: 1'b1, a: 2'b00, b: 2'b01};
         3'd1: p = '{two: 1'b0, a: 2'b00, b: 2'b00};
         3'd2: p = '{two: 1'b1, a: 2'b10, b: 2'b00};
         3'd3: p = '{two: 1'b0, a: 2'b10, b: 2'b00};
         3'd4: p = '{two: 1'b1, a: 2'b10, b: 2'b11};
         3'd5: p = '{two: 1'b0, a: 2'b11, b: 2'b00};
         3'd6: p = '{two: 1'b1, a: 2'b11, b: 2'b01};
         default: p = '{two: 1'b0, a: 2'b01, b: 2'b00};
      endcase
      return p;
   endfunction

endpackage

// File: hdl/getc_chan_if.sv
// Valid/ready channel interface carrying one payload item per transfer.
interface getc_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/getc_ram.sv
// Generic single-port RAM with registered read data.
module getc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/getc_seq.sv
// Sequencer: command decode, window scan address walk, shared max unit, result register.
`include "grid_edge_traversal_cost_defines.svh"

module getc_seq #(
   parameter int GRID_ROWS = 256,
   parameter int GRID_COLS = 256,
   localparam int ADDR_W = $clog2(GRID_ROWS * GRID_COLS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  getc_pkg::cfg_type    cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  getc_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output getc_pkg::rsp_type    rsp_data,
   output logic [ADDR_W-1:0]    ram_addr,
   output logic                 ram_we,
   output logic [7:0]           ram_wdata,
   input  logic [7:0]           ram_rdata
);

   localparam int DW = getc_pkg::DIM_W;
   localparam int SW = getc_pkg::SC_W;

   getc_pkg::state_type state_ff, state_in;
   getc_pkg::req_type   req_ff, req_in;
   getc_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rd_pend_ff, rd_pend_in;
   logic                sel_ff, sel_in;
   logic [7:0]          best_ff, best_in;
   logic [DW-1:0]       i_ff, i_in, j_ff, j_in;
   logic [DW-1:0]       r1_ff, r1_in, c0_ff, c0_in, c1_ff, c1_in;

   logic [DW-1:0]        nr, nc, req_row_u, req_col_u, addr_row, addr_col;
   logic                 in_grid, outside, more_cells, scan_last, emit_go;
   getc_pkg::cell_pair_type pair;
   logic [1:0]           off;
   logic signed [SW-1:0] cr, cc, nr_s, nc_s, rad_s;
   logic signed [SW-1:0] lo_r, hi_r, lo_c, hi_c, r0_s, r1_s, c0_s, c1_s;
   logic [7:0]           cand, max_val;
   logic                 cand_en, blk;

   // grid in use, clipped to the physical array
   assign nr = (DW'(cfg.rows_in_use) < DW'(GRID_ROWS)) ? DW'(cfg.rows_in_use) : DW'(GRID_ROWS);
   assign nc = (DW'(cfg.cols_in_use) < DW'(GRID_COLS)) ? DW'(cfg.cols_in_use) : DW'(GRID_COLS);

   assign req_row_u = DW'(req_ff.row);
   assign req_col_u = DW'(req_ff.col);
   assign in_grid   = (req_row_u < nr) && (req_col_u < nc);

   // current examined cell and its clipped window bounds
   assign pair       = getc_pkg::dir_cells(req_ff.direction);
   assign off        = sel_ff ? pair.b : pair.a;
   assign more_cells = pair.two && !sel_ff;

   assign cr    = $signed(SW'(req_ff.row)) - $signed(SW'(off[1]));
   assign cc    = $signed(SW'(req_ff.col)) - $signed(SW'(off[0]));
   assign nr_s  = $signed(SW'(nr));
   assign nc_s  = $signed(SW'(nc));
   assign rad_s = $signed(SW'(cfg.window_radius));

   assign outside = (cr < 0) || (cc < 0) || (cr >= nr_s) || (cc >= nc_s);

   assign lo_r = cr - rad_s;
   assign hi_r = cr + rad_s;
   assign lo_c = cc - rad_s;
   assign hi_c = cc + rad_s;
   assign r0_s = (lo_r < 0) ? '0 : lo_r;
   assign c0_s = (lo_c < 0) ? '0 : lo_c;
   assign r1_s = (hi_r > nr_s - SW'(1)) ? nr_s - SW'(1) : hi_r;
   assign c1_s = (hi_c > nc_s - SW'(1)) ? nc_s - SW'(1) : hi_c;

   assign scan_last = (i_ff == r1_ff) && (j_ff == c1_ff);

   // memory address: scan counters while walking a window, else the item's cell
   assign addr_row  = (state_ff == getc_pkg::ST_SCAN) ? i_ff : req_row_u;
   assign addr_col  = (state_ff == getc_pkg::ST_SCAN) ? j_ff : req_col_u;
   assign ram_addr  = ADDR_W'(addr_row) * ADDR_W'(GRID_COLS) + ADDR_W'(addr_col);
   assign ram_wdata = req_ff.cell_value;

   // shared max unit: read data, or 255 for a cell beyond the grid
   assign cand    = (state_ff == getc_pkg::ST_CELL) ? 8'hFF : ram_rdata;
   assign cand_en = rd_pend_ff || ((state_ff == getc_pkg::ST_CELL) && outside);
   assign max_val = (cand > best_ff) ? cand : best_ff;

   assign blk     = best_ff > cfg.block_threshold;
   assign emit_go = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == getc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         getc_pkg::ST_IDLE: begin
            if (req_valid) state_in = getc_pkg::ST_DECODE;
         end
         getc_pkg::ST_DECODE: begin
            case (req_ff.op)
               getc_pkg::OP_LOAD:   state_in = getc_pkg::ST_IDLE;
               getc_pkg::OP_UPDATE: state_in = in_grid ? getc_pkg::ST_CMP : getc_pkg::ST_IDLE;
               getc_pkg::OP_QUERY:  state_in = getc_pkg::ST_CELL;
               default:             state_in = getc_pkg::ST_IDLE;
            endcase
         end
         getc_pkg::ST_CMP: begin
            state_in = (ram_rdata != req_ff.cell_value) ? getc_pkg::ST_EMIT
                                                         : getc_pkg::ST_IDLE;
         end
         getc_pkg::ST_CELL: begin
            if (!outside) state_in = getc_pkg::ST_SCAN;
            else if (!more_cells) state_in = getc_pkg::ST_EMIT;
         end
         getc_pkg::ST_SCAN: begin
            if (scan_last) state_in = getc_pkg::ST_DRAIN;
         end
         getc_pkg::ST_DRAIN: begin
            state_in = more_cells ? getc_pkg::ST_CELL : getc_pkg::ST_EMIT;
         end
         getc_pkg::ST_EMIT: begin
            if (emit_go) state_in = getc_pkg::ST_IDLE;
         end
         default: state_in = getc_pkg::ST_IDLE;
      endcase
   end

   // datapath controls and register loads
   always_comb begin
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_pend_in   = 1'b0;
      sel_in       = sel_ff;
      best_in      = cand_en ? max_val : best_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      r1_in        = r1_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      ram_we       = 1'b0;
      case (state_ff)
         getc_pkg::ST_IDLE: begin
            if (req_valid) req_in = req_data;
         end
         getc_pkg::ST_DECODE: begin
            if (req_ff.op == getc_pkg::OP_LOAD) ram_we = in_grid;
            best_in = '0;
            sel_in  = 1'b0;
         end
         getc_pkg::ST_CMP: begin
            ram_we = 1'b1;
         end
         getc_pkg::ST_CELL: begin
            if (!outside) begin
               i_in  = DW'(r0_s);
               j_in  = DW'(c0_s);
               c0_in = DW'(c0_s);
               r1_in = DW'(r1_s);
               c1_in = DW'(c1_s);
            end else if (more_cells) begin
               sel_in = 1'b1;
            end
         end
         getc_pkg::ST_SCAN: begin
            rd_pend_in = 1'b1;
            if (j_ff == c1_ff) begin
               j_in = c0_ff;
               i_in = i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         getc_pkg::ST_DRAIN: begin
            if (more_cells) sel_in = 1'b1;
         end
         getc_pkg::ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in      = 1'b1;
               rsp_in.out_row    = req_ff.row;
               rsp_in.out_col    = req_ff.col;
               if (req_ff.op == getc_pkg::OP_QUERY) begin
                  rsp_in.kind       = getc_pkg::KIND_COST;
                  rsp_in.blocked    = blk;
                  rsp_in.cost       = blk ? '0 : (req_ff.direction[0] ? cfg.diagonal_cost
                                                                       : cfg.edge_cost);
                  rsp_in.window_max = best_ff;
               end else begin
                  rsp_in.kind       = getc_pkg::KIND_REPORT;
                  rsp_in.blocked    = 1'b0;
                  rsp_in.cost       = '0;
                  rsp_in.window_max = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= getc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      sel_ff  <= sel_in;
      best_ff <= best_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      r1_ff   <= r1_in;
      c0_ff   <= c0_in;
      c1_ff   <= c1_in;
   end

   `GETC_ASSERT_IMP(a_we_only_on_write, clock, reset, ram_we, (state_ff == getc_pkg::ST_DECODE) || (state_ff == getc_pkg::ST_CMP))
   `GETC_ASSERT_IMP(a_scan_in_window, clock, reset, state_ff == getc_pkg::ST_SCAN, (i_ff <= r1_ff) && (j_ff <= c1_ff))
   `GETC_ASSERT_IMP(a_pend_after_scan, clock, reset, rd_pend_ff, $past(state_ff) == getc_pkg::ST_SCAN)
   `GETC_ASSERT_IMP(a_report_clean, clock, reset, rsp_valid_ff && (rsp_ff.kind == getc_pkg::KIND_REPORT), !rsp_ff.blocked && (rsp_ff.cost == '0) && (rsp_ff.window_max == '0))

endmodule

// File: hdl/grid_edge_traversal_cost.sv
// Top level: configuration registers, occupancy memory and sequencer.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------
//  req_chan | in  | valid / ready      | op, row, col, cell_value, direction
//  rsp_chan | out | valid / ready      | kind, out_row, out_col, blocked, cost, window_max
//  csr_*    | in  | csr_write_en       | csr_index, csr_wdata
//
// One item at a time. Load: decode and write. Update: decode and compare, plus a report state
// to post a change report. Query: decode, then per examined cell a setup and a drain state and
// one memory read per window cell (up to (2*radius+1)^2); a cell beyond the grid costs only its
// setup state. The single memory read port sets the scan rate: one window cell per cycle.
// A result waiting on rsp_chan does not stop the next transfer in; the block stalls only
// at its result stage. Reset is synchronous; the occupancy memory is not cleared.
module grid_edge_traversal_cost #(
   parameter int GRID_ROWS = 256,
   parameter int GRID_COLS = 256
) (
   input  logic        clock,
   input  logic        reset,
   getc_chan_if.sink   req_chan,
   getc_chan_if.source rsp_chan,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int DEPTH  = GRID_ROWS * GRID_COLS;
   localparam int ADDR_W = $clog2(DEPTH);

   getc_pkg::cfg_type cfg_ff, cfg_in;
   logic [ADDR_W-1:0] ram_addr;
   logic              ram_we;
   logic [7:0]        ram_wdata, ram_rdata;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            getc_pkg::CSR_ROWS_IN_USE:     cfg_in.rows_in_use     = csr_wdata[8:0];
            getc_pkg::CSR_COLS_IN_USE:     cfg_in.cols_in_use     = csr_wdata[8:0];
            getc_pkg::CSR_WINDOW_RADIUS:   cfg_in.window_radius   = csr_wdata[3:0];
            getc_pkg::CSR_BLOCK_THRESHOLD: cfg_in.block_threshold = csr_wdata[7:0];
            getc_pkg::CSR_EDGE_COST:       cfg_in.edge_cost       = csr_wdata;
            getc_pkg::CSR_DIAGONAL_COST:   cfg_in.diagonal_cost   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows_in_use     <= 9'd256;
         cfg_ff.cols_in_use     <= 9'd256;
         cfg_ff.window_radius   <= 4'd1;
         cfg_ff.block_threshold <= 8'd150;
         cfg_ff.edge_cost       <= 16'd256;
         cfg_ff.diagonal_cost   <= 16'd362;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // occupancy grid
   getc_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_grid_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   getc_seq #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_data  (req_chan.payload),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (rsp_chan.payload),
      .ram_addr  (ram_addr),
      .ram_we    (ram_we),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata)
   );

endmodule

// File: tb/tb.sv
// Self-checking testbench for grid_edge_traversal_cost: directed and random traffic.
module tb;

   localparam int GRID_N       = 256;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int IDLE_SETTLE  = 16;
   localparam int END_SETTLE   = 32;
   localparam int ITEM_TARGET  = 650;
   localparam int HOLDOFF_LEN  = 400;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef enum int {RX_ALWAYS, RX_SPARSE, RX_CHOPPY} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   getc_chan_if #(.payload_type(getc_pkg::req_type)) req_if ();
   getc_chan_if #(.payload_type(getc_pkg::rsp_type)) rsp_if ();

   grid_edge_traversal_cost u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // predicted grid contents, which cells were written, and register copy
   bit [7:0]          occ_grid  [GRID_N*GRID_N];
   bit                occ_known [GRID_N*GRID_N];
   getc_pkg::cfg_type cfg_shadow;
   getc_pkg::rsp_type answers_due [$];

   int          error_count     = 0;
   int          cycle_count     = 0;
   int          tx_burst_left   = 0;
   int          tx_gap_max      = 4;
   int          items_sent      = 0;
   rx_mode_type rx_mode         = RX_ALWAYS;
   int          holdoff_request = 0;
   int          holdoff_left    = 0;
   int          rx_run_left     = 0;
   bit          rx_run_on       = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[grid_edge_traversal_cost] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic int used_rows();
      return (cfg_shadow.rows_in_use < GRID_N) ? int'(cfg_shadow.rows_in_use) : GRID_N;
   endfunction

   function automatic int used_cols();
      return (cfg_shadow.cols_in_use < GRID_N) ? int'(cfg_shadow.cols_in_use) : GRID_N;
   endfunction

   function automatic bit cell_in_grid(input int row, input int col);
      return row >= 0 && col >= 0 && row < used_rows() && col < used_cols();
   endfunction

   // clipped window around a cell; returns 0 for a cell off the grid
   function automatic bit window_span(input int row, input int col,
                                      output int r0, output int r1,
                                      output int c0, output int c1);
      int nr, nc, rad;
      nr  = used_rows();
      nc  = used_cols();
      rad = int'(cfg_shadow.window_radius);
      r0  = 0;
      r1  = -1;
      c0  = 0;
      c1  = -1;
      if (!cell_in_grid(row, col)) return 1'b0;
      r0 = (row - rad < 0) ? 0 : row - rad;
      r1 = (row + rad > nr - 1) ? nr - 1 : row + rad;
      c0 = (col - rad < 0) ? 0 : col - rad;
      c1 = (col + rad > nc - 1) ? nc - 1 : col + rad;
      return 1'b1;
   endfunction

   function automatic bit [7:0] window_peak(input int row, input int col);
      int r0, r1, c0, c1;
      bit [7:0] best;
      best = 8'd0;
      if (!window_span(row, col, r0, r1, c0, c1)) return 8'hFF;
      for (int i = r0; i <= r1; i++)
         for (int j = c0; j <= c1; j++)
            if (occ_grid[i*GRID_N + j] > best) best = occ_grid[i*GRID_N + j];
      return best;
   endfunction

   // k-th cell beside the edge; diagonals have one cell, straight edges two
   function automatic bit edge_cell(input logic [2:0] dir, input int k,
                                    input int row, input int col,
                                    output int cr, output int cc);
      case (dir)
         3'd0: begin cr = row;                       cc = (k == 0) ? col : col - 1; end
         3'd1: begin cr = row;                       cc = col;                      end
         3'd2: begin cr = (k == 0) ? row - 1 : row;  cc = col;                      end
         3'd3: begin cr = row - 1;                   cc = col;                      end
         3'd4: begin cr = row - 1;                   cc = (k == 0) ? col : col - 1; end
         3'd5: begin cr = row - 1;                   cc = col - 1;                  end
         3'd6: begin cr = (k == 0) ? row - 1 : row;  cc = col - 1;                  end
         default: begin cr = row;                    cc = col - 1;                  end
      endcase
      return (k == 0) || !dir[0];
   endfunction

   // applies one request to the predicted grid; returns 1 when it yields a result
   function automatic bit compute_answer(input getc_pkg::req_type rq,
                                         output getc_pkg::rsp_type ans);
      int row, col, idx, cr, cc;
      bit [7:0] peak, v;
      bit blk;
      ans = '0;
      row = int'(rq.row);
      col = int'(rq.col);
      if (rq.op == getc_pkg::OP_LOAD || rq.op == getc_pkg::OP_UPDATE) begin
         if (!cell_in_grid(row, col)) return 1'b0;
         idx = row*GRID_N + col;
         if (rq.op == getc_pkg::OP_LOAD || occ_grid[idx] == rq.cell_value) begin
            occ_grid[idx]  = rq.cell_value;
            occ_known[idx] = 1'b1;
            return 1'b0;
         end
         occ_grid[idx] = rq.cell_value;
         ans.kind    = getc_pkg::KIND_REPORT;
         ans.out_row = rq.row;
         ans.out_col = rq.col;
         return 1'b1;
      end
      if (rq.op == getc_pkg::OP_QUERY) begin
         peak = 8'd0;
         for (int k = 0; k < 2; k++) begin
            if (edge_cell(rq.direction, k, row, col, cr, cc)) begin
               v = window_peak(cr, cc);
               if (v > peak) peak = v;
            end
         end
         blk = peak > cfg_shadow.block_threshold;
         ans.kind       = getc_pkg::KIND_COST;
         ans.out_row    = rq.row;
         ans.out_col    = rq.col;
         ans.blocked    = blk;
         ans.cost       = blk ? 16'd0 :
                          (rq.direction[0] ? cfg_shadow.diagonal_cost : cfg_shadow.edge_cost);
         ans.window_max = peak;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------- result side

   // receiver: long hold-off on request, otherwise its own stall pattern
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (holdoff_left > 0) begin
            rsp_if.ready <= 1'b0;
            holdoff_left--;
         end else if (holdoff_request > 0) begin
            holdoff_left    = holdoff_request - 1;
            holdoff_request = 0;
            rsp_if.ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_ALWAYS: rsp_if.ready <= 1'b1;
               RX_SPARSE: rsp_if.ready <= ($urandom_range(3, 0) != 0);
               default: begin
                  if (rx_run_left == 0) begin
                     rx_run_on   = !rx_run_on;
                     rx_run_left = rx_run_on ? $urandom_range(8, 1) : $urandom_range(24, 1);
                  end
                  rx_run_left--;
                  rsp_if.ready <= rx_run_on;
               end
            endcase
         end
      end
   end

   function automatic void check_field(input string fname, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
         error_count++;
      end
   endfunction

   // each result transfer against the oldest expectation
   always @(posedge clock) begin
      getc_pkg::rsp_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (answers_due.size() == 0) begin
            $error("unexpected result: kind %0d row %0d col %0d",
                   got.kind, got.out_row, got.out_col);
            error_count++;
         end else begin
            want = answers_due.pop_front();
            check_field("kind", 16'(want.kind), 16'(got.kind));
            check_field("out_row", 16'(want.out_row), 16'(got.out_row));
            check_field("out_col", 16'(want.out_col), 16'(got.out_col));
            check_field("blocked", 16'(want.blocked), 16'(got.blocked));
            check_field("cost", want.cost, got.cost);
            check_field("window_max", 16'(want.window_max), 16'(got.window_max));
         end
      end
   end

   // ---------------------------------------------------------------- request side

   function automatic getc_pkg::req_type make_req(input logic [1:0] op, input int row,
                                                  input int col, input int value,
                                                  input int dir);
      getc_pkg::req_type rq;
      rq.op         = op;
      rq.row        = row[8:0];
      rq.col        = col[8:0];
      rq.cell_value = value[7:0];
      rq.direction  = dir[2:0];
      return rq;
   endfunction

   // occupancy level: extremes, around the threshold, or anything
   function automatic int pick_level();
      int v;
      case ($urandom_range(3, 0))
         0: v = $urandom_range(1, 0) ? 255 : 0;
         1: begin
            v = int'(cfg_shadow.block_threshold) + int'($urandom_range(2, 0)) - 1;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
         end
         default: v = $urandom_range(255, 0);
      endcase
      return v;
   endfunction

   // one request transfer; sender works in bursts separated by random gaps
   task automatic send_item(input getc_pkg::req_type rq);
      getc_pkg::rsp_type ans;
      int gap;
      if (tx_burst_left == 0) begin
         tx_burst_left = $urandom_range(16, 1);
         gap = $urandom_range(tx_gap_max, 0);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      tx_burst_left--;
      req_if.valid   <= 1'b1;
      req_if.payload <= rq;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      if (compute_answer(rq, ans)) answers_due = {answers_due, ans};
   endtask

   task automatic send_load(input int row, input int col, input int value);
      send_item(make_req(getc_pkg::OP_LOAD, row, col, value, $urandom_range(7, 0)));
   endtask

   // the compare of an update reads the cell, so it must hold a value first
   task automatic send_update(input int row, input int col, input int value);
      if (cell_in_grid(row, col) && !occ_known[row*GRID_N + col])
         send_load(row, col, pick_level());
      send_item(make_req(getc_pkg::OP_UPDATE, row, col, value, $urandom_range(7, 0)));
   endtask

   // loads any unwritten cell the query would scan, then sends the query
   task automatic send_query(input int row, input int col, input logic [2:0] dir);
      int cr, cc, r0, r1, c0, c1;
      for (int k = 0; k < 2; k++) begin
         if (edge_cell(dir, k, row, col, cr, cc) && window_span(cr, cc, r0, r1, c0, c1)) begin
            for (int i = r0; i <= r1; i++)
               for (int j = c0; j <= c1; j++)
                  if (!occ_known[i*GRID_N + j]) send_load(i, j, pick_level());
         end
      end
      send_item(make_req(getc_pkg::OP_QUERY, row, col, $urandom_range(255, 0), int'(dir)));
   endtask

   task automatic random_queries(input int count);
      repeat (count)
         send_query($urandom_range(used_rows(), 0), $urandom_range(used_cols(), 0),
                    3'($urandom_range(7, 0)));
   endtask

   // sender pause: nothing outstanding and any silent item finished
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      tx_burst_left = 0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      case (index)
         getc_pkg::CSR_ROWS_IN_USE:     cfg_shadow.rows_in_use     = value[8:0];
         getc_pkg::CSR_COLS_IN_USE:     cfg_shadow.cols_in_use     = value[8:0];
         getc_pkg::CSR_WINDOW_RADIUS:   cfg_shadow.window_radius   = value[3:0];
         getc_pkg::CSR_BLOCK_THRESHOLD: cfg_shadow.block_threshold = value[7:0];
         getc_pkg::CSR_EDGE_COST:       cfg_shadow.edge_cost       = value;
         getc_pkg::CSR_DIAGONAL_COST:   cfg_shadow.diagonal_cost   = value;
         default: ;
      endcase
   endtask

   task automatic set_register(input logic [2:0] index, input logic [15:0] value);
      wait_idle();
      write_register(index, value);
      csr_write_en <= 1'b0;
   endtask

   task automatic apply_config(input int rows, input int cols, input int radius,
                               input int thresh, input int straight, input int diag);
      wait_idle();
      write_register(getc_pkg::CSR_ROWS_IN_USE, 16'(rows));
      write_register(getc_pkg::CSR_COLS_IN_USE, 16'(cols));
      write_register(getc_pkg::CSR_WINDOW_RADIUS, 16'(radius));
      write_register(getc_pkg::CSR_BLOCK_THRESHOLD, 16'(thresh));
      write_register(getc_pkg::CSR_EDGE_COST, 16'(straight));
      write_register(getc_pkg::CSR_DIAGONAL_COST, 16'(diag));
      csr_write_en <= 1'b0;
   endtask

   // mostly well-formed traffic, some writes off the grid and unused ops
   task automatic random_item();
      int pick, nr, nc, row, col, v;
      nr   = used_rows();
      nc   = used_cols();
      row  = $urandom_range(nr - 1, 0);
      col  = $urandom_range(nc - 1, 0);
      pick = $urandom_range(99, 0);
      if (pick < 30) begin
         send_load(row, col, pick_level());
      end else if (pick < 52) begin
         v = (occ_known[row*GRID_N + col] && $urandom_range(1, 0)) ?
             int'(occ_grid[row*GRID_N + col]) : pick_level();
         send_update(row, col, v);
      end else if (pick < 92) begin
         row = ($urandom_range(4, 0) == 0) ? $urandom_range(511, 0) : $urandom_range(nr, 0);
         col = ($urandom_range(4, 0) == 0) ? $urandom_range(511, 0) : $urandom_range(nc, 0);
         send_query(row, col, 3'($urandom_range(7, 0)));
      end else begin
         case ($urandom_range(2, 0))
            0: send_item(make_req(OP_UNUSED, $urandom_range(511, 0), $urandom_range(511, 0),
                                  $urandom_range(255, 0), $urandom_range(7, 0)));
            1: send_load($urandom_range(511, nr), col, $urandom_range(255, 0));
            default: send_update(row, $urandom_range(511, nc), $urandom_range(255, 0));
         endcase
      end
   endtask

   // ---------------------------------------------------------------- tests

   // power-up registers: full grid, radius 1, threshold 150
   task automatic test_reset_defaults();
      send_query(0, 0, 3'd1);
      send_query(256, 256, 3'd5);
      send_query(256, 256, 3'd1);
      send_query(0, 0, 3'd0);
      send_query(511, 511, 3'd6);
      send_item(make_req(OP_UNUSED, 511, 511, 255, 7));
   endtask

   // zero radius on a 2x3 grid: every direction, unchanged and off-grid writes
   task automatic test_small_grid();
      apply_config(2, 3, 0, 0, 16'hFFFF, 16'h0000);
      send_load(0, 0, 0);
      send_load(0, 1, 0);
      send_load(0, 2, 255);
      send_load(1, 0, 0);
      send_load(1, 1, 0);
      send_load(1, 2, 1);
      send_update(1, 2, 1);
      send_update(1, 2, 128);
      send_update(2, 0, 7);
      send_load(511, 0, 255);
      send_update(0, 256, 3);
      for (int d = 0; d < 8; d++) send_query(1, 1, 3'(d));
      send_query(2, 3, 3'd5);
   endtask

   // no rows in use: writes vanish and every scanned cell counts 255
   task automatic test_empty_grid();
      apply_config(0, 511, 2, 255, 100, 200);
      send_load(0, 0, 5);
      send_update(0, 0, 6);
      send_query(0, 0, 3'd1);
      send_query(0, 0, 3'd2);
      set_register(getc_pkg::CSR_BLOCK_THRESHOLD, 16'd254);
      send_query(0, 0, 3'd1);
      send_query(1, 1, 3'd4);
   endtask

   // each register at its extremes
   task automatic test_register_extremes();
      apply_config(1, 1, 15, 0, 16'h0000, 16'hFFFF);
      random_queries(4);
      apply_config(256, 1, 15, 255, 16'hFFFF, 16'h0000);
      random_queries(3);
      apply_config(1, 256, 15, 128, 16'h8000, 16'h7FFF);
      random_queries(3);
      apply_config(256, 256, 1, 150, 256, 362);
      send_query(256, 0, 3'd4);
      send_query(0, 256, 3'd2);
      send_query(256, 256, 3'd6);
   endtask

   // receiver holds off while the sender keeps offering queries
   task automatic test_backpressure();
      apply_config(6, 6, 1, 100, 300, 424);
      rx_mode    = RX_ALWAYS;
      tx_gap_max = 0;
      for (int i = 0; i < 6; i++)
         for (int j = 0; j < 6; j++)
            send_load(i, j, pick_level());
      holdoff_request = HOLDOFF_LEN;
      random_queries(24);
   endtask

   // short bursts, each followed by a full drain
   task automatic test_sender_pause();
      apply_config(8, 8, 2, 120, 512, 724);
      rx_mode    = RX_CHOPPY;
      tx_gap_max = 3;
      repeat (6) begin
         repeat (5) random_item();
         wait_idle();
      end
   endtask

   // random phases, each under a fresh register setting, up to the item budget
   task automatic test_random();
      int rows, cols, radius;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(9, 0) == 0) begin
            rows   = $urandom_range(256, 1);
            cols   = $urandom_range(256, 1);
            radius = $urandom_range(1, 0);
         end else begin
            rows   = $urandom_range(12, 1);
            cols   = $urandom_range(12, 1);
            radius = ($urandom_range(3, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(3, 0);
         end
         apply_config(rows, cols, radius, $urandom_range(255, 0),
                      $urandom_range(65535, 0), $urandom_range(65535, 0));
         rx_mode    = rx_mode_type'($urandom_range(2, 0));
         tx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
         repeat ($urandom_range(90, 30))
            if (items_sent < ITEM_TARGET) random_item();
      end
   endtask

   initial begin
      reset          <= 1'b1;
      csr_write_en   <= 1'b0;
      csr_index      <= getc_pkg::CSR_ROWS_IN_USE;
      csr_wdata      <= '0;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      cfg_shadow = '{rows_in_use: 9'd256, cols_in_use: 9'd256, window_radius: 4'd1,
                     block_threshold: 8'd150, edge_cost: 16'd256, diagonal_cost: 16'd362};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_small_grid();
      test_empty_grid();
      test_register_extremes();
      test_backpressure();
      test_sender_pause();
      test_random();

      wait_idle();
      repeat (END_SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("[grid_edge_traversal_cost] OK");
      else
         $display("[grid_edge_traversal_cost] ERROR");
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/getc_pkg.sv
hdl/getc_chan_if.sv
hdl/getc_ram.sv
hdl/getc_seq.sv
hdl/grid_edge_traversal_cost.sv
tb/tb.sv
